// ----- hw/rtl/ctf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complementary tilt filter package
// Shared widths, register indexes, reset values, the arctangent table,
// the request types of both channels and the saturation helper.
// ----------------------------------------------------------------------------
package ctf_pkg;

    // Number of CORDIC vectoring steps (8 to 32).
    localparam int CORDIC_ITERATIONS = 16;

    // Arctangent table depth and the index width that follows from it.
    localparam int ATAN_DEPTH = 32;
    localparam int ITER_IDX_W = $clog2(ATAN_DEPTH);

    // Datapath widths.
    localparam int ANGLE_W        = 32;
    localparam int CORDIC_W       = 32;
    localparam int CORDIC_SCALE   = 14;
    localparam int SAT_W          = 36;
    localparam int MUL_MCAND_W    = 34;
    localparam int MUL_MPLIER_W   = 16;
    localparam int MUL_PROD_W     = MUL_MCAND_W + MUL_MPLIER_W;
    localparam int MUL_CNT_W      = $clog2(MUL_MPLIER_W);
    localparam int MIX_W          = 52;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_COEFF  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GYRO_GAIN    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_OFFSET = 2'd2;

    localparam logic [15:0]        BLEND_COEFF_RESET  = 16'd62259;
    localparam logic [23:0]        GYRO_GAIN_RESET    = 24'd8600;
    localparam logic signed [31:0] ACCEL_OFFSET_RESET = 32'sd0;

    // Ninety degrees in 1/65536 degree.
    localparam logic signed [ANGLE_W-1:0] DEG90 = 32'sd5898240;

    // Rounding terms for the gyro increment and the blend.
    localparam logic [39:0]             INCR_ROUND = 40'd128;
    localparam logic signed [MIX_W-1:0] MIX_ROUND  = 52'sd32768;

    // Saturation limits on the widened intermediate.
    localparam logic signed [SAT_W-1:0] SAT_MAX = 36'sd2147483647;
    localparam logic signed [SAT_W-1:0] SAT_MIN = -36'sd2147483648;

    // atan(2^-i) in 1/65536 degree.
    localparam logic signed [ANGLE_W-1:0] ATAN_LUT [ATAN_DEPTH] = '{
        32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945,
        32'sd234379,  32'sd117304,  32'sd58666,  32'sd29335,
        32'sd14668,   32'sd7334,    32'sd3667,   32'sd1833,
        32'sd917,     32'sd458,     32'sd229,    32'sd115,
        32'sd57,      32'sd29,      32'sd14,     32'sd7,
        32'sd4,       32'sd2,       32'sd1,      32'sd0,
        32'sd0,       32'sd0,       32'sd0,      32'sd0,
        32'sd0,       32'sd0,       32'sd0,      32'sd0
    };

    // Input request: one raw IMU sample.
    typedef struct packed {
        logic              kind;
        logic signed [15:0] gyro_rate;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } t_in_item;

    // Output request: the three angles.
    typedef struct packed {
        logic signed [31:0] accel_angle;
        logic signed [31:0] gyro_angle;
        logic signed [31:0] fused_angle;
    } t_out_item;

    // Control of one serial multiplier run.
    typedef struct packed {
        logic start;
        logic signed_mplier;
    } t_mul_ctrl;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_PREP1,
        ST_PREP2,
        ST_BLEND_GO,
        ST_BLEND,
        ST_FINISH
    } t_state;

    // Clamp a widened signed value to the 32-bit range.
    function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [ANGLE_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[ANGLE_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[ANGLE_W-1:0];
        end else begin
            r = v[ANGLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/complementary_tilt_filter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complementary tilt filter
// Accelerometer tilt by CORDIC, gyro integration and complementary blend of
// the two, with bit-serial multipliers for the gain and the blend weight.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Payload
//   input     in         i_in_valid / o_in_stall   i_in_data   (t_in_item)
//   output    out        o_out_valid / i_out_stall o_out_data  (t_out_item)
//   config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// A filter sample runs the CORDIC loop, one micro-rotation a cycle, followed
// by the 16-step bit-serial blend multiplier; a seed skips the blend. The
// gyro product runs alongside the CORDIC. Reset is synchronous and clears
// both stored angles and the registers to their defaults. A stalled result
// sits in the output register while the next request is already taken;
// only a second finished result waits for it.
// ----------------------------------------------------------------------------
module complementary_tilt_filter_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  ctf_pkg::t_in_item                     i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output ctf_pkg::t_out_item                    o_out_data,
    input  logic                                  i_cfg_we,
    input  logic [ctf_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [ctf_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import ctf_pkg::*;

    t_state                      r_state, n_state;

    logic [15:0]                 r_blend_coeff;
    logic [23:0]                 r_gyro_gain;
    logic signed [31:0]          r_accel_offset;

    logic                        r_kind;
    logic                        r_seed_ok;
    logic                        r_cordic_flag;
    logic                        r_gyro_flag;
    logic signed [ANGLE_W-1:0]   r_raw;
    logic signed [ANGLE_W-1:0]   r_accel;
    logic signed [ANGLE_W-1:0]   r_incr;
    logic signed [ANGLE_W:0]     r_sum;
    logic signed [ANGLE_W-1:0]   r_gyro_next;
    logic signed [ANGLE_W-1:0]   r_gyro_angle;
    logic signed [ANGLE_W-1:0]   r_fused_angle;
    logic                        r_out_valid;
    t_out_item                   r_out;

    logic                        in_accept;
    logic                        out_free;
    logic                        finish_fire;
    logic                        cordic_start;
    logic                        cordic_done;
    logic signed [ANGLE_W-1:0]   cordic_angle;
    t_mul_ctrl                   gyro_ctrl, blend_ctrl;
    logic                        gyro_done, blend_done;
    logic signed [MUL_PROD_W-1:0] gyro_prod, blend_prod;
    logic signed [MUL_MCAND_W-1:0] gyro_mcand, blend_mcand;

    logic signed [ANGLE_W-1:0]   raw_tilt;
    logic [39:0]                 incr_round;
    logic signed [MIX_W-1:0]     mix;
    logic signed [ANGLE_W-1:0]   fused_mixed;
    logic signed [ANGLE_W-1:0]   new_gyro, new_fused;

    // Accelerometer tilt: atan2(z, y).
    ctf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_vec_y (i_in_data.accel_z),
        .i_vec_x (i_in_data.accel_y),
        .o_done  (cordic_done),
        .o_angle (cordic_angle)
    );

    // Gyro product: rate times gain, runs alongside the CORDIC.
    assign gyro_mcand = MUL_MCAND_W'($signed({1'b0, r_gyro_gain}));

    ctf_serial_mul u_gyro_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (gyro_ctrl),
        .i_mcand   (gyro_mcand),
        .i_mplier  (i_in_data.gyro_rate),
        .o_done    (gyro_done),
        .o_product (gyro_prod)
    );

    // Blend product: k times (sum - accel).
    assign blend_mcand = MUL_MCAND_W'(r_sum) - MUL_MCAND_W'(r_accel);

    ctf_serial_mul u_blend_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (blend_ctrl),
        .i_mcand   (blend_mcand),
        .i_mplier  (r_blend_coeff),
        .o_done    (blend_done),
        .o_product (blend_prod)
    );

    // Handshake terms.
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (r_cordic_flag && r_gyro_flag) n_state = ST_PREP1;
            end
            ST_PREP1: begin
                n_state = r_kind ? ST_FINISH : ST_PREP2;
            end
            ST_PREP2: begin
                n_state = ST_BLEND_GO;
            end
            ST_BLEND_GO: begin
                n_state = ST_BLEND;
            end
            ST_BLEND: begin
                if (blend_done) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall               = (r_state != ST_IDLE);
        cordic_start             = (r_state == ST_IDLE) && i_in_valid;
        gyro_ctrl.start          = (r_state == ST_IDLE) && i_in_valid;
        gyro_ctrl.signed_mplier  = 1'b1;
        blend_ctrl.start         = (r_state == ST_BLEND_GO);
        blend_ctrl.signed_mplier = 1'b0;
        finish_fire              = (r_state == ST_FINISH) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_coeff  <= BLEND_COEFF_RESET;
            r_gyro_gain    <= GYRO_GAIN_RESET;
            r_accel_offset <= ACCEL_OFFSET_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BLEND_COEFF:  r_blend_coeff  <= i_cfg_data[15:0];
                CFG_GYRO_GAIN:    r_gyro_gain    <= i_cfg_data[23:0];
                CFG_ACCEL_OFFSET: r_accel_offset <= $signed(i_cfg_data[31:0]);
                default: begin
                end
            endcase
        end
    end

    // Completion flags of the two units started with the request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cordic_flag <= 1'b0;
            r_gyro_flag   <= 1'b0;
        end else if (in_accept) begin
            r_cordic_flag <= 1'b0;
            r_gyro_flag   <= 1'b0;
        end else begin
            if (cordic_done) r_cordic_flag <= 1'b1;
            if (gyro_done)   r_gyro_flag   <= 1'b1;
        end
    end

    // Request attributes kept for the later steps.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind    <= i_in_data.kind;
            r_seed_ok <= (i_in_data.accel_z != 16'sd0);
        end
    end

    // First preparation step: tilt, offset tilt and rounded gyro increment.
    assign raw_tilt   = cordic_angle - DEG90;
    assign incr_round = gyro_prod[39:0] + INCR_ROUND;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PREP1) begin
            r_raw   <= raw_tilt;
            r_accel <= sat32(SAT_W'(raw_tilt) + SAT_W'(r_accel_offset));
            r_incr  <= $signed(incr_round[39:8]);
        end
    end

    // Second preparation step: predicted angle and the new gyro angle.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PREP2) begin
            r_sum       <= (ANGLE_W + 1)'(r_fused_angle) + (ANGLE_W + 1)'(r_incr);
            r_gyro_next <= sat32(SAT_W'(r_gyro_angle) + SAT_W'(r_incr));
        end
    end

    // Blend: accel * 65536 + k * (sum - accel), rounded, back to 1/65536 degree.
    assign mix         = $signed({SAT_W'(r_accel), 16'd0}) + MIX_W'(blend_prod) + MIX_ROUND;
    assign fused_mixed = sat32($signed(mix[MIX_W-1:16]));

    // Values of the stored angles after this request.
    always_comb begin
        if (r_kind) begin
            new_gyro  = r_seed_ok ? r_raw : r_gyro_angle;
            new_fused = r_seed_ok ? r_raw : r_fused_angle;
        end else begin
            new_gyro  = r_gyro_next;
            new_fused = fused_mixed;
        end
    end

    // Stored angles.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_angle  <= '0;
            r_fused_angle <= '0;
        end else if (finish_fire) begin
            r_gyro_angle  <= new_gyro;
            r_fused_angle <= new_fused;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish_fire) begin
            r_out.accel_angle <= r_accel;
            r_out.gyro_angle  <= new_gyro;
            r_out.fused_angle <= new_fused;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("Input not stalled after a request was taken.");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_FINISH))
        else $error("Result appeared outside the finishing step.");

    a_cordic_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cordic_done |-> (r_state == ST_RUN))
        else $error("CORDIC finished while the sequencer was not waiting.");

endmodule

// ----- hw/rtl/ctf_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC arctangent unit
// Iterative vectoring CORDIC giving atan2(y, x) in 1/65536 degree, one
// micro-rotation per clock, with a quadrant pre-rotation on start.
// ----------------------------------------------------------------------------
module ctf_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [15:0]                i_vec_y,
    input  logic signed [15:0]                i_vec_x,
    output logic                              o_done,
    output logic signed [ctf_pkg::ANGLE_W-1:0] o_angle
);
    import ctf_pkg::*;

    logic signed [CORDIC_W-1:0] x_scaled, y_scaled;
    logic signed [CORDIC_W-1:0] pre_x, pre_y;
    logic signed [ANGLE_W-1:0]  pre_ang;
    logic signed [CORDIC_W-1:0] x_sh, y_sh;
    logic signed [CORDIC_W-1:0] n_x, n_y;
    logic signed [ANGLE_W-1:0]  n_ang;
    logic                       last_step;

    logic signed [CORDIC_W-1:0] r_x, r_y;
    logic signed [ANGLE_W-1:0]  r_ang;
    logic [ITER_IDX_W-1:0]      r_idx;
    logic                       r_zero;
    logic                       r_busy;
    logic                       r_done;

    // Scale the raw counts up so that the shifts keep precision.
    assign x_scaled = CORDIC_W'($signed({i_vec_x, {CORDIC_SCALE{1'b0}}}));
    assign y_scaled = CORDIC_W'($signed({i_vec_y, {CORDIC_SCALE{1'b0}}}));

    // Points in the left half-plane are turned by a quarter first.
    always_comb begin
        pre_x   = x_scaled;
        pre_y   = y_scaled;
        pre_ang = '0;
        if (x_scaled < 0) begin
            if (y_scaled >= 0) begin
                pre_x   = y_scaled;
                pre_y   = -x_scaled;
                pre_ang = DEG90;
            end else begin
                pre_x   = -y_scaled;
                pre_y   = x_scaled;
                pre_ang = -DEG90;
            end
        end
    end

    // One vectoring micro-rotation, steering y towards zero.
    assign x_sh      = r_x >>> r_idx;
    assign y_sh      = r_y >>> r_idx;
    assign last_step = (r_idx == ITER_IDX_W'(CORDIC_ITERATIONS - 1));

    always_comb begin
        if (r_y > 0) begin
            n_x   = r_x + y_sh;
            n_y   = r_y - x_sh;
            n_ang = r_ang + ATAN_LUT[r_idx];
        end else begin
            n_x   = r_x - y_sh;
            n_y   = r_y + x_sh;
            n_ang = r_ang - ATAN_LUT[r_idx];
        end
    end

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last_step) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Vector and angle registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= pre_x;
            r_y    <= pre_y;
            r_ang  <= pre_ang;
            r_idx  <= '0;
            r_zero <= (i_vec_x == 16'sd0) && (i_vec_y == 16'sd0);
        end else if (r_busy) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_ang <= n_ang;
            r_idx <= r_idx + 1'b1;
        end
    end

    // The zero vector has no direction and reads as zero.
    assign o_done  = r_done;
    assign o_angle = r_zero ? '0 : r_ang;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("CORDIC started while still iterating.");

endmodule

// ----- hw/rtl/ctf_serial_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-and-add multiplier taking one multiplier bit per clock, least
// significant first; the top bit may carry negative weight.
// ----------------------------------------------------------------------------
module ctf_serial_mul (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ctf_pkg::t_mul_ctrl                      i_ctrl,
    input  logic signed [ctf_pkg::MUL_MCAND_W-1:0]  i_mcand,
    input  logic [ctf_pkg::MUL_MPLIER_W-1:0]        i_mplier,
    output logic                                    o_done,
    output logic signed [ctf_pkg::MUL_PROD_W-1:0]   o_product
);
    import ctf_pkg::*;

    logic signed [MUL_MCAND_W:0]            mcand_ext;
    logic signed [MUL_MCAND_W:0]            addend;
    logic signed [MUL_MCAND_W:0]            psum;
    logic                                   last_step;
    logic [MUL_MCAND_W+MUL_MPLIER_W:0]      full_prod;

    logic signed [MUL_MCAND_W:0]            r_hi;
    logic [MUL_MPLIER_W-1:0]                r_lo;
    logic signed [MUL_MCAND_W-1:0]          r_mcand;
    logic                                   r_neg_top;
    logic [MUL_CNT_W-1:0]                   r_cnt;
    logic                                   r_busy;
    logic                                   r_done;

    assign mcand_ext = (MUL_MCAND_W + 1)'(r_mcand);
    assign last_step = (r_cnt == MUL_CNT_W'(MUL_MPLIER_W - 1));

    // Partial product for the current multiplier bit; a signed top bit subtracts.
    always_comb begin
        if (r_lo[0]) begin
            addend = (last_step && r_neg_top) ? -mcand_ext : mcand_ext;
        end else begin
            addend = '0;
        end
        psum = r_hi + addend;
    end

    // Step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last_step) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Accumulator and multiplier shift register, shifted right each step.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_hi      <= '0;
            r_lo      <= i_mplier;
            r_mcand   <= i_mcand;
            r_neg_top <= i_ctrl.signed_mplier;
            r_cnt     <= '0;
        end else if (r_busy) begin
            r_hi  <= {psum[MUL_MCAND_W], psum[MUL_MCAND_W:1]};
            r_lo  <= {psum[0], r_lo[MUL_MPLIER_W-1:1]};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign full_prod = {r_hi, r_lo};
    assign o_done    = r_done;
    assign o_product = $signed(full_prod[MUL_PROD_W-1:0]);

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |-> !r_busy)
        else $error("Multiplier started while still busy.");

endmodule
